>>> hdl/ppau_pkg.sv
// ----------------------------------------------------------------------------
// Pixel pair arithmetic unit package
// Operation codes, register indexes, pipeline control type and the
// integer square root step shared by the datapath modules.
// ----------------------------------------------------------------------------
package ppau_pkg;

	// Operation codes held in the mode register
	localparam logic [3:0] MODE_ADD     = 4'd0;
	localparam logic [3:0] MODE_SUB     = 4'd1;
	localparam logic [3:0] MODE_ABSDIFF = 4'd2;
	localparam logic [3:0] MODE_MUL     = 4'd3;
	localparam logic [3:0] MODE_AVG     = 4'd4;
	localparam logic [3:0] MODE_FADE    = 4'd5;
	localparam logic [3:0] MODE_MIN     = 4'd6;
	localparam logic [3:0] MODE_MAX     = 4'd7;
	localparam logic [3:0] MODE_AMPL    = 4'd8;
	localparam logic [3:0] MODE_AND     = 4'd9;
	localparam logic [3:0] MODE_OR      = 4'd10;
	localparam logic [3:0] MODE_XOR     = 4'd11;

	// Configuration register indexes
	localparam logic REG_OP_MODE     = 1'b0;
	localparam logic REG_FADE_WEIGHT = 1'b1;

	// Register reset values and limits
	localparam logic [3:0] OP_MODE_RESET     = MODE_ADD;
	localparam logic [8:0] FADE_WEIGHT_RESET = 9'd128;
	localparam logic [8:0] FADE_ONE          = 9'd256;
	localparam logic [7:0] PIX_MAX           = 8'd255;

	// Square root iterations done in each of the two root stages
	localparam int SqrtStepsPerStage = 4;

	// Control that travels alongside each pixel
	typedef struct packed {
		logic       valid;
		logic       last;
		logic [3:0] mode;
	} ctl_t;

	// Partial state of the bit-by-bit square root
	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] root;
	} sqrt_t;

	// One iteration of the restoring square root
	function automatic sqrt_t sqrt_step(sqrt_t s, logic [15:0] bit_val);
		sqrt_t       r;
		logic [16:0] trial;
		trial = {1'b0, s.root} + {1'b0, bit_val};
		if ({1'b0, s.rem} >= trial) begin
			r.rem  = s.rem - trial[15:0];
			r.root = (s.root >> 1) + bit_val;
		end else begin
			r.rem  = s.rem;
			r.root = s.root >> 1;
		end
		return r;
	endfunction

endpackage

>>> hdl/ppau_front.sv
// ----------------------------------------------------------------------------
// Pixel pair arithmetic unit front stage
// Captures a pixel pair, forms the arithmetic, logical and compare
// results and the products that the multiply, fade and amplitude modes need.
// ----------------------------------------------------------------------------
module ppau_front import ppau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [7:0]  pixel_a,
	input  logic [7:0]  pixel_b,
	input  logic        end_of_image,
	input  logic [3:0]  op_mode,
	input  logic [8:0]  fade_weight,
	output ctl_t        ctl_s1,
	output logic [7:0]  simple_s1,
	output logic [15:0] prod_ab_s1,
	output logic [15:0] sq_a_s1,
	output logic [15:0] sq_b_s1,
	output logic [15:0] fade_a_s1,
	output logic [15:0] fade_b_s1
);

	logic [8:0]  sum_ab;
	logic [7:0]  diff_ab;
	logic [7:0]  diff_ba;
	logic [7:0]  simple;
	logic [8:0]  weight;
	logic [8:0]  weight_inv;
	logic [16:0] fade_a_full;
	logic [16:0] fade_b_full;

	// Form the simple results
	always_comb begin
		sum_ab  = {1'b0, pixel_a} + {1'b0, pixel_b};
		diff_ab = pixel_a - pixel_b;
		diff_ba = pixel_b - pixel_a;
		case (op_mode)
			MODE_ADD:     simple = sum_ab[8] ? PIX_MAX : sum_ab[7:0];
			MODE_SUB:     simple = (pixel_a > pixel_b) ? diff_ab : 8'd0;
			MODE_ABSDIFF: simple = (pixel_a > pixel_b) ? diff_ab : diff_ba;
			MODE_AVG:     simple = sum_ab[8:1];
			MODE_MIN:     simple = (pixel_a < pixel_b) ? pixel_a : pixel_b;
			MODE_MAX:     simple = (pixel_a > pixel_b) ? pixel_a : pixel_b;
			MODE_AND:     simple = pixel_a & pixel_b;
			MODE_OR:      simple = pixel_a | pixel_b;
			MODE_XOR:     simple = pixel_a ^ pixel_b;
			default:      simple = 8'd0;
		endcase
	end

	// Clamp the weight to one and form the weighted products
	always_comb begin
		weight      = (fade_weight > FADE_ONE) ? FADE_ONE : fade_weight;
		weight_inv  = FADE_ONE - weight;
		fade_a_full = {9'd0, pixel_a} * {8'd0, weight};
		fade_b_full = {9'd0, pixel_b} * {8'd0, weight_inv};
	end

	// Advance the control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start;
			ctl_s1.last  <= end_of_image;
			ctl_s1.mode  <= op_mode;
		end
	end

	// Register the payload
	always_ff @(posedge clk) begin
		simple_s1  <= simple;
		prod_ab_s1 <= {8'd0, pixel_a} * {8'd0, pixel_b};
		sq_a_s1    <= {8'd0, pixel_a} * {8'd0, pixel_a};
		sq_b_s1    <= {8'd0, pixel_b} * {8'd0, pixel_b};
		fade_a_s1  <= fade_a_full[15:0];
		fade_b_s1  <= fade_b_full[15:0];
	end

endmodule

>>> hdl/ppau_combine.sv
// ----------------------------------------------------------------------------
// Pixel pair arithmetic unit combine stage
// Divides the product by 255, sums the fade terms and halves the sum of
// squares that feeds the square root.
// ----------------------------------------------------------------------------
module ppau_combine import ppau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl_s1,
	input  logic [7:0]  simple_s1,
	input  logic [15:0] prod_ab_s1,
	input  logic [15:0] sq_a_s1,
	input  logic [15:0] sq_b_s1,
	input  logic [15:0] fade_a_s1,
	input  logic [15:0] fade_b_s1,
	output ctl_t        ctl_s2,
	output logic [7:0]  simple_s2,
	output logic [7:0]  mul_s2,
	output logic [7:0]  fade_s2,
	output logic [15:0] radicand_s2
);

	logic [16:0] div_sum;
	logic [16:0] fade_sum;
	logic [16:0] sq_sum;

	// Floor divide by 255 for values below 2^16: (x + 1 + x/256) / 256
	always_comb begin
		div_sum  = {1'b0, prod_ab_s1} + 17'd1 + {9'd0, prod_ab_s1[15:8]};
		fade_sum = {1'b0, fade_a_s1} + {1'b0, fade_b_s1};
		sq_sum   = {1'b0, sq_a_s1} + {1'b0, sq_b_s1};
	end

	// Advance the control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Register the payload
	always_ff @(posedge clk) begin
		simple_s2   <= simple_s1;
		mul_s2      <= div_sum[15:8];
		fade_s2     <= fade_sum[15:8];
		radicand_s2 <= sq_sum[16:1];
	end

endmodule

>>> hdl/ppau_isqrt.sv
// ----------------------------------------------------------------------------
// Pixel pair arithmetic unit square root
// Two-stage pipelined integer square root of a 16-bit value, four
// restoring iterations in each stage.
// ----------------------------------------------------------------------------
module ppau_isqrt import ppau_pkg::*; (
	input  logic        clk,
	input  logic [15:0] radicand_s2,
	output logic [7:0]  root_s4
);

	sqrt_t part_s3;
	sqrt_t step_hi;
	sqrt_t step_lo;

	// Resolve the upper four root bits
	always_comb begin
		step_hi.rem  = radicand_s2;
		step_hi.root = 16'd0;
		for (int k = 0; k < SqrtStepsPerStage; k++) begin
			step_hi = sqrt_step(step_hi, 16'd1 << (14 - 2 * k));
		end
	end

	// Resolve the lower four root bits
	always_comb begin
		step_lo = part_s3;
		for (int k = 0; k < SqrtStepsPerStage; k++) begin
			step_lo = sqrt_step(step_lo, 16'd1 << (6 - 2 * k));
		end
	end

	// Hold the partial and final roots
	always_ff @(posedge clk) begin
		part_s3 <= step_hi;
		root_s4 <= step_lo.root[7:0];
	end

endmodule

>>> hdl/pixel_pair_arithmetic_unit.sv
// Throughput: one pixel pair per clock; busy stays low, so start may be high
// in every cycle, and the five register stages carry one item each.
// The receiver cannot stall: each result shows for one cycle on result_valid.
// Reset (arst_n low, asynchronous) clears all valid bits, sets op_mode to
// add and fade_weight to 128.
// ----------------------------------------------------------------------------
// Pixel pair arithmetic unit
// Combines two co-located 8-bit pixels by the operation held in op_mode
// through a five-stage pipeline.
// ----------------------------------------------------------------------------
module pixel_pair_arithmetic_unit import ppau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] pixel_a,
	input  logic [7:0] pixel_b,
	input  logic       end_of_image,
	output logic       result_valid,
	output logic [7:0] pixel_out,
	output logic       last_out,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data
);

	logic [3:0]  op_mode_q;
	logic [8:0]  fade_weight_q;
	ctl_t        ctl_s1;
	ctl_t        ctl_s2;
	ctl_t        ctl_s3;
	ctl_t        ctl_s4;
	logic [7:0]  simple_s1;
	logic [15:0] prod_ab_s1;
	logic [15:0] sq_a_s1;
	logic [15:0] sq_b_s1;
	logic [15:0] fade_a_s1;
	logic [15:0] fade_b_s1;
	logic [7:0]  simple_s2;
	logic [7:0]  mul_s2;
	logic [7:0]  fade_s2;
	logic [15:0] radicand_s2;
	logic [7:0]  simple_s3;
	logic [7:0]  mul_s3;
	logic [7:0]  fade_s3;
	logic [7:0]  simple_s4;
	logic [7:0]  mul_s4;
	logic [7:0]  fade_s4;
	logic [7:0]  root_s4;
	logic [7:0]  result;
	logic        valid_s5;
	logic        last_s5;
	logic [7:0]  pixel_s5;

	// The pipeline takes a transfer every cycle
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Write the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q     <= OP_MODE_RESET;
			fade_weight_q <= FADE_WEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OP_MODE:     op_mode_q     <= cfg_data[3:0];
				REG_FADE_WEIGHT: fade_weight_q <= cfg_data;
				default:         op_mode_q     <= op_mode_q;
			endcase
		end
	end

	ppau_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.pixel_a      (pixel_a),
		.pixel_b      (pixel_b),
		.end_of_image (end_of_image),
		.op_mode      (op_mode_q),
		.fade_weight  (fade_weight_q),
		.ctl_s1       (ctl_s1),
		.simple_s1    (simple_s1),
		.prod_ab_s1   (prod_ab_s1),
		.sq_a_s1      (sq_a_s1),
		.sq_b_s1      (sq_b_s1),
		.fade_a_s1    (fade_a_s1),
		.fade_b_s1    (fade_b_s1)
	);

	ppau_combine u_combine (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_s1      (ctl_s1),
		.simple_s1   (simple_s1),
		.prod_ab_s1  (prod_ab_s1),
		.sq_a_s1     (sq_a_s1),
		.sq_b_s1     (sq_b_s1),
		.fade_a_s1   (fade_a_s1),
		.fade_b_s1   (fade_b_s1),
		.ctl_s2      (ctl_s2),
		.simple_s2   (simple_s2),
		.mul_s2      (mul_s2),
		.fade_s2     (fade_s2),
		.radicand_s2 (radicand_s2)
	);

	ppau_isqrt u_isqrt (
		.clk         (clk),
		.radicand_s2 (radicand_s2),
		.root_s4     (root_s4)
	);

	// Advance the control alongside the square root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// Delay the finished results to meet the root
	always_ff @(posedge clk) begin
		simple_s3 <= simple_s2;
		mul_s3    <= mul_s2;
		fade_s3   <= fade_s2;
		simple_s4 <= simple_s3;
		mul_s4    <= mul_s3;
		fade_s4   <= fade_s3;
	end

	// Select the result of the chosen operation
	always_comb begin
		case (ctl_s4.mode)
			MODE_MUL:  result = mul_s4;
			MODE_FADE: result = fade_s4;
			MODE_AMPL: result = root_s4;
			default:   result = simple_s4;
		endcase
	end

	// Drive the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= ctl_s4.valid;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		pixel_s5 <= result;
		last_s5  <= ctl_s4.last;
	end

	assign result_valid = valid_s5;
	assign pixel_out    = pixel_s5;
	assign last_out     = last_s5;

endmodule
